// ----- src/dcpc_pkg.sv -----
`timescale 1ns / 1ps
package dcpc_pkg;

   localparam int unsigned COEF_WIDTH_DEF = 16;
   localparam int unsigned LANE_WIDTH     = 16;
   localparam int unsigned NUM_SETS       = 3;
   localparam int unsigned ACC_WIDTH      = 32;

   localparam logic [2:0] KIND_LOWER_SENTRY  = 3'd0;
   localparam logic [2:0] KIND_HIGHER_SENTRY = 3'd1;
   localparam logic [2:0] KIND_HERO          = 3'd2;
   localparam logic [2:0] KIND_INFANTRY      = 3'd3;
   localparam logic [2:0] KIND_NONE          = 3'd4;

   localparam logic [2:0] REG_KIND        = 3'd0;
   localparam logic [2:0] REG_SET0_DIST   = 3'd1;
   localparam logic [2:0] REG_SET0_PITCH  = 3'd2;
   localparam logic [2:0] REG_SET1_DIST   = 3'd3;
   localparam logic [2:0] REG_SET1_PITCH  = 3'd4;
   localparam logic [2:0] REG_SET2_DIST   = 3'd5;
   localparam logic [2:0] REG_SET2_PITCH  = 3'd6;

   localparam logic [1:0] SET0 = 2'd0;
   localparam logic [1:0] SET1 = 2'd1;
   localparam logic [1:0] SET2 = 2'd2;

   localparam logic [5:0] SPEED_HERO_SET0 = 6'd10;
   localparam logic [5:0] SPEED_HERO_SET1 = 6'd16;
   localparam logic [5:0] SPEED_INF_SET0  = 6'd15;
   localparam logic [5:0] SPEED_INF_SET1  = 6'd18;
   localparam logic [5:0] SPEED_INF_SET2  = 6'd30;

   localparam logic [15:0] RANGE_OUTPOST_MIN = 16'd768;
   localparam logic [15:0] RANGE_HERO_NEAR   = 16'd512;

   localparam logic signed [31:0] HERO_NEAR_DELTA = 32'sd4260;

   typedef struct packed {
      logic signed [19:0] pitch_in;
      logic [5:0]         speed_mps;
      logic [15:0]        range_q8;
      logic               outpost_mode;
      logic signed [31:0] check_in;
   } req_type;

   typedef struct packed {
      logic signed [19:0] pitch_out;
      logic signed [31:0] check_out;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic               apply;
      logic               to_check;
      logic               use_poly;
      logic               near;
      logic               single;
      logic [1:0]         set;
      logic signed [19:0] pitch;
      logic signed [31:0] check;
      logic [15:0]        range_q8;
      logic signed [31:0] acc;
      logic signed [31:0] plane;
   } item_type;

   function automatic logic signed [15:0] lane_coef(input logic [63:0] regval,
                                                     input logic [1:0] idx,
                                                     input int unsigned cw);
      logic [15:0]        raw;
      logic signed [15:0] tmp;
      raw = regval[idx * LANE_WIDTH +: LANE_WIDTH];
      tmp = signed'(raw << (LANE_WIDTH - cw));
      return tmp >>> (LANE_WIDTH - cw);
   endfunction

endpackage

// ----- src/dcpc_decode.sv -----
`timescale 1ns / 1ps
module dcpc_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dcpc_pkg::req_type req_data,
   input  logic [2:0]        kind,
   output dcpc_pkg::item_type item
);
   import dcpc_pkg::*;

   item_type item_ff;
   item_type item_in;

   always_comb begin
      item_in          = '0;
      item_in.valid    = start;
      item_in.pitch    = req_data.pitch_in;
      item_in.check    = req_data.check_in;
      item_in.range_q8 = req_data.range_q8;
      item_in.apply    = (req_data.pitch_in != '0) && (req_data.speed_mps != '0) &&
                         (req_data.range_q8 != '0) && (kind <= KIND_INFANTRY);
      item_in.to_check = 1'b1;
      item_in.set      = SET0;
      case (kind)
         KIND_LOWER_SENTRY: begin
            item_in.use_poly = 1'b1;
            item_in.single   = 1'b1;
            item_in.to_check = 1'b0;
         end
         KIND_HIGHER_SENTRY: begin
            item_in.use_poly = 1'b1;
            item_in.set      = SET2;
         end
         KIND_HERO: begin
            if (req_data.outpost_mode) begin
               item_in.use_poly = req_data.range_q8 > RANGE_OUTPOST_MIN;
               item_in.set      = SET2;
            end else begin
               case (req_data.speed_mps)
                  SPEED_HERO_SET0: begin
                     item_in.use_poly = 1'b1;
                     item_in.set      = SET0;
                  end
                  SPEED_HERO_SET1: begin
                     item_in.use_poly = 1'b1;
                     item_in.set      = SET1;
                  end
                  default: item_in.use_poly = 1'b0;
               endcase
               item_in.near = req_data.range_q8 < RANGE_HERO_NEAR;
            end
         end
         KIND_INFANTRY: begin
            case (req_data.speed_mps)
               SPEED_INF_SET0: begin
                  item_in.use_poly = 1'b1;
                  item_in.set      = SET0;
               end
               SPEED_INF_SET1: begin
                  item_in.use_poly = 1'b1;
                  item_in.set      = SET1;
               end
               SPEED_INF_SET2: begin
                  item_in.use_poly = 1'b1;
                  item_in.set      = SET2;
               end
               default: item_in.use_poly = 1'b0;
            endcase
         end
         default: item_in.use_poly = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// ----- src/dcpc_horner_step.sv -----
`timescale 1ns / 1ps
module dcpc_horner_step #(
   parameter int unsigned COEF_WIDTH = dcpc_pkg::COEF_WIDTH_DEF,
   parameter int unsigned X_WIDTH    = 17,
   parameter int unsigned FRAC       = 8,
   parameter int unsigned LANE       = 1,
   parameter bit          NEG_SINGLE = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dcpc_pkg::item_type        item,
   input  logic signed [X_WIDTH-1:0] x,
   input  logic [2:0][63:0]          coefs,
   output dcpc_pkg::item_type        item_out
);
   import dcpc_pkg::*;

   localparam int unsigned PROD_WIDTH = ACC_WIDTH + X_WIDTH;
   localparam int unsigned SUM_WIDTH  = PROD_WIDTH + 2;
   localparam int unsigned ADD_WIDTH  = LANE_WIDTH + 5;
   localparam logic signed [SUM_WIDTH-1:0] HALF    = SUM_WIDTH'(1) <<< (FRAC - 1);
   localparam logic signed [SUM_WIDTH-1:0] ACC_MAX = (SUM_WIDTH'(1) <<< (ACC_WIDTH - 1)) - 1;
   localparam logic signed [SUM_WIDTH-1:0] ACC_MIN = -(SUM_WIDTH'(1) <<< (ACC_WIDTH - 1));

   item_type                     mid_ff;
   item_type                     out_ff;
   item_type                     out_in;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;
   logic signed [ADD_WIDTH-1:0]  addend;
   logic signed [SUM_WIDTH-1:0]  sum;
   logic signed [SUM_WIDTH-1:0]  rnd;

   assign prod_in = PROD_WIDTH'(item.acc) * PROD_WIDTH'(x);

   always_comb begin
      addend = ADD_WIDTH'(lane_coef(coefs[mid_ff.set], 2'(LANE), COEF_WIDTH)) <<< 4;
      if (NEG_SINGLE && mid_ff.single) begin
         addend = -addend;
      end
      sum = SUM_WIDTH'(prod_ff) + ((SUM_WIDTH'(addend) <<< FRAC) | HALF);
      rnd = sum >>> FRAC;
      out_in = mid_ff;
      if (!((LANE > 1) && mid_ff.single)) begin
         if (rnd > ACC_MAX) begin
            out_in.acc = ACC_MAX[ACC_WIDTH-1:0];
         end else if (rnd < ACC_MIN) begin
            out_in.acc = ACC_MIN[ACC_WIDTH-1:0];
         end else begin
            out_in.acc = rnd[ACC_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= '0;
         out_ff <= '0;
      end else begin
         mid_ff <= item;
         out_ff <= out_in;
      end
   end

   assign item_out = out_ff;

endmodule

// ----- src/dcpc_output.sv -----
`timescale 1ns / 1ps
module dcpc_output (
   input  logic               clock,
   input  logic               reset,
   input  dcpc_pkg::item_type item,
   output logic               rsp_valid,
   output dcpc_pkg::rsp_type  rsp_data
);
   import dcpc_pkg::*;

   localparam logic signed [33:0] PITCH_MAX = 34'sd524287;
   localparam logic signed [33:0] PITCH_MIN = -34'sd524288;
   localparam logic signed [33:0] CHECK_MAX = 34'sd2147483647;
   localparam logic signed [33:0] CHECK_MIN = -34'sd2147483648;

   logic               valid_ff;
   logic               valid_in;
   rsp_type            data_ff;
   rsp_type            data_in;
   logic signed [31:0] delta;
   logic signed [33:0] pitch_diff;
   logic signed [33:0] check_diff;

   always_comb begin
      if (item.near) begin
         delta = HERO_NEAR_DELTA;
      end else if (item.use_poly) begin
         delta = item.acc;
      end else begin
         delta = '0;
      end
      pitch_diff = 34'(item.pitch) - 34'(delta);
      check_diff = 34'(item.check) - 34'(delta);
      data_in.pitch_out = item.pitch;
      data_in.check_out = item.check;
      if (item.apply) begin
         if (pitch_diff > PITCH_MAX) begin
            data_in.pitch_out = PITCH_MAX[19:0];
         end else if (pitch_diff < PITCH_MIN) begin
            data_in.pitch_out = PITCH_MIN[19:0];
         end else begin
            data_in.pitch_out = pitch_diff[19:0];
         end
         if (item.to_check) begin
            if (check_diff > CHECK_MAX) begin
               data_in.check_out = CHECK_MAX[31:0];
            end else if (check_diff < CHECK_MIN) begin
               data_in.check_out = CHECK_MIN[31:0];
            end else begin
               data_in.check_out = check_diff[31:0];
            end
         end
      end
      valid_in = item.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- src/dual_cubic_pitch_compensator_core.sv -----
`timescale 1ns / 1ps
// A transaction accepted on start appears on rsp_data with rsp_valid high at the end of the
// pipeline, and a new transaction may be started in every cycle, so busy stays low. The
// pipeline is made of the six Horner multiply-accumulate steps of the two cubics, each a
// multiplier stage followed by a round, add and saturate stage, plus one decode and one
// output stage. Results are shown for one cycle only and cannot be held off by the receiver.
// Configuration writes take effect at once and belong in periods with no transaction in flight.
module dual_cubic_pitch_compensator_core #(
   parameter int unsigned COEF_WIDTH = dcpc_pkg::COEF_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dcpc_pkg::req_type req_data,
   output logic              rsp_valid,
   output dcpc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [63:0]       csr_wdata
);
   import dcpc_pkg::*;

   logic [2:0]       kind_ff;
   logic [2:0][63:0] dist_ff;
   logic [2:0][63:0] pitch_ff;

   item_type dec_item;
   item_type dist_chain [0:3];
   item_type pitch_chain [0:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_NONE;
         dist_ff  <= '0;
         pitch_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_KIND:       kind_ff     <= csr_wdata[2:0];
            REG_SET0_DIST:  dist_ff[0]  <= csr_wdata;
            REG_SET0_PITCH: pitch_ff[0] <= csr_wdata;
            REG_SET1_DIST:  dist_ff[1]  <= csr_wdata;
            REG_SET1_PITCH: pitch_ff[1] <= csr_wdata;
            REG_SET2_DIST:  dist_ff[2]  <= csr_wdata;
            REG_SET2_PITCH: pitch_ff[2] <= csr_wdata;
            default:        kind_ff     <= kind_ff;
         endcase
      end
   end

   dcpc_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .kind     (kind_ff),
      .item     (dec_item)
   );

   always_comb begin
      dist_chain[0]     = dec_item;
      dist_chain[0].acc = ACC_WIDTH'(lane_coef(dist_ff[dec_item.set], 2'd0, COEF_WIDTH)) <<< 4;
   end

   always_comb begin
      pitch_chain[0]       = dist_chain[3];
      pitch_chain[0].plane = dist_chain[3].acc;
      pitch_chain[0].acc   =
         ACC_WIDTH'(lane_coef(pitch_ff[dist_chain[3].set], 2'd0, COEF_WIDTH)) <<< 4;
   end

   for (genvar g = 0; g < 3; g++) begin : g_steps
      dcpc_horner_step #(
         .COEF_WIDTH (COEF_WIDTH),
         .X_WIDTH    (17),
         .FRAC       (8),
         .LANE       (g + 1),
         .NEG_SINGLE (g == 0)
      ) u_dist_step (
         .clock    (clock),
         .reset    (reset),
         .item     (dist_chain[g]),
         .x        (signed'({1'b0, dist_chain[g].range_q8})),
         .coefs    (dist_ff),
         .item_out (dist_chain[g+1])
      );

      dcpc_horner_step #(
         .COEF_WIDTH (COEF_WIDTH),
         .X_WIDTH    (ACC_WIDTH),
         .FRAC       (16),
         .LANE       (g + 1),
         .NEG_SINGLE (1'b0)
      ) u_pitch_step (
         .clock    (clock),
         .reset    (reset),
         .item     (pitch_chain[g]),
         .x        (pitch_chain[g].plane),
         .coefs    (pitch_ff),
         .item_out (pitch_chain[g+1])
      );
   end

   dcpc_output u_output (
      .clock     (clock),
      .reset     (reset),
      .item      (pitch_chain[3]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign busy = 1'b0;

endmodule

// ----- tb/pitch_comp_checker.sv -----
`timescale 1ns / 1ps
module pitch_comp_checker #(
   parameter int unsigned COEF_WIDTH = dcpc_pkg::COEF_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  dcpc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  dcpc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [63:0]       csr_wdata,
   output int                mismatches,
   output int                in_flight
);
   import dcpc_pkg::*;

   localparam int     HERO_SPEED_SET0   = 10;
   localparam int     HERO_SPEED_SET1   = 16;
   localparam int     INF_SPEED_SET0    = 15;
   localparam int     INF_SPEED_SET1    = 18;
   localparam int     INF_SPEED_SET2    = 30;
   localparam longint OUTPOST_MIN_RANGE = 768;
   localparam longint HERO_NEAR_RANGE   = 512;
   localparam longint HERO_NEAR_CORR    = 4260;

   logic [2:0]  kind_q;
   logic [63:0] dist_coefs_q [3];
   logic [63:0] pitch_coefs_q [3];
   rsp_type     predicted_aims [$];

   function automatic longint clamp(input longint v, input int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint round_half_up(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint lane(input logic [63:0] word, input int idx);
      logic signed [15:0] v;
      v = word[16 * idx +: 16] << (16 - COEF_WIDTH);
      return longint'(v >>> (16 - COEF_WIDTH));
   endfunction

   function automatic longint horner(input logic [63:0] word, input longint x, input int frac);
      longint acc;
      acc = lane(word, 0) * 16;
      for (int i = 1; i < 4; i++)
         acc = clamp(round_half_up(acc * x, frac) + lane(word, i) * 16, 32);
      return acc;
   endfunction

   function automatic longint set_correction(input int s, input longint d);
      return horner(pitch_coefs_q[s], horner(dist_coefs_q[s], d, 8), 16);
   endfunction

   function automatic rsp_type compensate_aim(input req_type r);
      longint  pitch, chk, d, delta, plane;
      logic    apply, to_check;
      rsp_type res;
      pitch = longint'(signed'(r.pitch_in));
      chk = longint'(signed'(r.check_in));
      d = longint'(r.range_q8);
      delta = 0;
      apply = 1'b1;
      to_check = 1'b1;
      if (r.pitch_in == 0 || r.speed_mps == 0 || r.range_q8 == 0 || kind_q > KIND_INFANTRY) begin
         apply = 1'b0;
      end else if (kind_q == KIND_LOWER_SENTRY) begin
         plane = clamp(round_half_up(lane(dist_coefs_q[0], 0) * d, 4)
                       - lane(dist_coefs_q[0], 1) * 16, 32);
         delta = clamp(round_half_up(lane(pitch_coefs_q[0], 0) * plane, 12)
                       + lane(pitch_coefs_q[0], 1) * 16, 32);
         to_check = 1'b0;
      end else if (kind_q == KIND_HIGHER_SENTRY) begin
         delta = set_correction(2, d);
      end else if (kind_q == KIND_HERO) begin
         if (r.outpost_mode) begin
            if (d > OUTPOST_MIN_RANGE) delta = set_correction(2, d);
         end else begin
            if (r.speed_mps == HERO_SPEED_SET0) delta = set_correction(0, d);
            else if (r.speed_mps == HERO_SPEED_SET1) delta = set_correction(1, d);
            if (d < HERO_NEAR_RANGE) delta = HERO_NEAR_CORR;
         end
      end else begin
         if (r.speed_mps == INF_SPEED_SET0) delta = set_correction(0, d);
         else if (r.speed_mps == INF_SPEED_SET1) delta = set_correction(1, d);
         else if (r.speed_mps == INF_SPEED_SET2) delta = set_correction(2, d);
      end
      if (apply) begin
         pitch = clamp(pitch - delta, 20);
         if (to_check) chk = clamp(chk - delta, 32);
      end
      res.pitch_out = pitch[19:0];
      res.check_out = chk[31:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         kind_q <= KIND_NONE;
         for (int s = 0; s < 3; s++) begin
            dist_coefs_q[s] <= '0;
            pitch_coefs_q[s] <= '0;
         end
         predicted_aims.delete();
         mismatches <= 0;
         in_flight <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_KIND:       kind_q <= csr_wdata[2:0];
               REG_SET0_DIST:  dist_coefs_q[0] <= csr_wdata;
               REG_SET0_PITCH: pitch_coefs_q[0] <= csr_wdata;
               REG_SET1_DIST:  dist_coefs_q[1] <= csr_wdata;
               REG_SET1_PITCH: pitch_coefs_q[1] <= csr_wdata;
               REG_SET2_DIST:  dist_coefs_q[2] <= csr_wdata;
               REG_SET2_PITCH: pitch_coefs_q[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (predicted_aims.size() == 0) begin
               $display("%0t: result with no transaction outstanding: pitch_out %h check_out %h",
                        $time, rsp_data.pitch_out, rsp_data.check_out);
               errs++;
            end else begin
               want = predicted_aims.pop_front();
               if (rsp_data.pitch_out !== want.pitch_out) begin
                  $display("%0t: pitch_out expected %h actual %h",
                           $time, want.pitch_out, rsp_data.pitch_out);
                  errs++;
               end
               if (rsp_data.check_out !== want.check_out) begin
                  $display("%0t: check_out expected %h actual %h",
                           $time, want.check_out, rsp_data.check_out);
                  errs++;
               end
            end
         end
         if (start && !busy) predicted_aims.push_back(compensate_aim(req_data));
         mismatches <= mismatches + errs;
         in_flight <= predicted_aims.size();
      end
   end

endmodule

// ----- tb/tb_dual_cubic_pitch_compensator_core.sv -----
`timescale 1ns / 1ps
module tb_dual_cubic_pitch_compensator_core;
   import dcpc_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int NUM_PHASES      = 16;
   localparam int ITEMS_PER_PHASE = 25;

   localparam int COEFS_RANDOM  = 0;
   localparam int COEFS_GENTLE  = 1;
   localparam int COEFS_EXTREME = 2;
   localparam int COEFS_ZERO    = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [63:0] csr_wdata = '0;
   int          mismatches;
   int          in_flight;
   int          idle_pct = 0;
   int          quiet_cycles = 0;

   always #2 clock = ~clock;

   dual_cubic_pitch_compensator_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   pitch_comp_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_type aim(input logic [19:0] pitch, input logic [5:0] speed,
                                   input logic [15:0] target_range, input logic outpost,
                                   input logic [31:0] chk);
      req_type r;
      r.pitch_in = pitch;
      r.speed_mps = speed;
      r.range_q8 = target_range;
      r.outpost_mode = outpost;
      r.check_in = chk;
      return r;
   endfunction

   function automatic logic [63:0] pick_coefs(input int mode, input int shrink);
      logic [63:0] w;
      int          span, v;
      w = {$urandom, $urandom};
      for (int i = 0; i < 4; i++) begin
         span = (i == 0) ? 16 : (i == 1) ? 256 : (i == 2) ? 8192 : 4096;
         v = (int'($urandom_range(2 * span)) - span) >>> shrink;
         case (mode)
            COEFS_GENTLE:  w[16 * i +: 16] = v[15:0];
            COEFS_EXTREME: w[16 * i +: 16] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            COEFS_ZERO:    w[16 * i +: 16] = '0;
            default: ;
         endcase
      end
      return w;
   endfunction

   function automatic req_type random_item(input logic [2:0] kind);
      req_type r;
      int      sel;
      sel = $urandom_range(19);
      if (sel == 0) r.pitch_in = '0;
      else if (sel == 1) r.pitch_in = 20'h80000;
      else if (sel == 2) r.pitch_in = 20'h7FFFF;
      else if (sel < 10) r.pitch_in = 20'(int'($urandom_range(65536)) - 32768);
      else r.pitch_in = 20'($urandom);
      sel = $urandom_range(9);
      if (kind == KIND_HERO && sel < 6) begin
         r.speed_mps = sel[0] ? SPEED_HERO_SET1 : SPEED_HERO_SET0;
      end else if (kind == KIND_INFANTRY && sel < 6) begin
         r.speed_mps = (sel < 2) ? SPEED_INF_SET0 : (sel < 4) ? SPEED_INF_SET1 : SPEED_INF_SET2;
      end else if (sel == 9) begin
         r.speed_mps = '0;
      end else begin
         r.speed_mps = 6'($urandom);
      end
      sel = $urandom_range(19);
      if (sel == 0) r.range_q8 = '0;
      else if (sel == 1) r.range_q8 = 16'hFFFF;
      else if (sel < 5) r.range_q8 = ($urandom_range(1) ? 16'd511 : 16'd767) + 16'($urandom_range(2));
      else if (sel < 13) r.range_q8 = 16'($urandom_range(3000));
      else r.range_q8 = 16'($urandom);
      r.outpost_mode = 1'($urandom_range(1));
      sel = $urandom_range(19);
      if (sel == 0) r.check_in = 32'h80000000;
      else if (sel == 1) r.check_in = 32'h7FFFFFFF;
      else r.check_in = $urandom;
      return r;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [2:0] kind, input int mode);
      logic [63:0] kind_word;
      kind_word = {$urandom, $urandom};
      kind_word[2:0] = kind;
      write_reg(REG_KIND, kind_word);
      write_reg(REG_SET0_DIST, pick_coefs(mode, 0));
      write_reg(REG_SET0_PITCH, pick_coefs(mode, 4));
      write_reg(REG_SET1_DIST, pick_coefs(mode, 0));
      write_reg(REG_SET1_PITCH, pick_coefs(mode, 4));
      write_reg(REG_SET2_DIST, pick_coefs(mode, 0));
      write_reg(REG_SET2_PITCH, pick_coefs(mode, 4));
      csr_we <= 1'b0;
   endtask

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds off new transactions until every outstanding result has been seen.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [2:0] kind;
      int         mode;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_item(aim(20'h7FFFF, 6'd63, 16'hFFFF, 1'b1, 32'h7FFFFFFF));
      send_item(aim(20'h80000, 6'd1, 16'd1, 1'b0, 32'h80000000));
      drain();

      configure(KIND_HERO, COEFS_GENTLE);
      send_item(aim(20'h80000, SPEED_HERO_SET0, 16'd256, 1'b0, 32'h80000000));
      send_item(aim(20'd1000, SPEED_HERO_SET0, 16'd511, 1'b0, 32'd5000));
      send_item(aim(20'd1000, SPEED_HERO_SET0, 16'd512, 1'b0, 32'd5000));
      send_item(aim(20'hFF000, SPEED_HERO_SET1, 16'd1024, 1'b0, 32'hFFFFFFF9));
      send_item(aim(20'd3000, 6'd11, 16'd1024, 1'b0, 32'd0));
      send_item(aim(20'd3000, 6'd11, 16'd256, 1'b0, 32'd0));
      send_item(aim(20'd3000, SPEED_HERO_SET0, 16'd768, 1'b1, 32'd100));
      send_item(aim(20'd3000, SPEED_HERO_SET0, 16'd769, 1'b1, 32'd100));
      send_item(aim(20'd3000, 6'd63, 16'hFFFF, 1'b1, 32'h7FFFFFFF));
      send_item(aim(20'd0, SPEED_HERO_SET0, 16'd256, 1'b0, 32'd9));
      send_item(aim(20'd3000, 6'd0, 16'd256, 1'b0, 32'd9));
      send_item(aim(20'd3000, SPEED_HERO_SET0, 16'd0, 1'b0, 32'd9));
      send_item(aim(20'h7FFFF, SPEED_HERO_SET1, 16'd100, 1'b0, 32'h7FFFFFFF));
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         kind = (p < 12) ? 3'(p % 4) : 3'(p - 8);
         if (p == 3) mode = COEFS_EXTREME;
         else if (p == 7) mode = COEFS_ZERO;
         else if (p == 5 || p == 10) mode = COEFS_RANDOM;
         else mode = COEFS_GENTLE;
         configure(kind, mode);
         idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 65 : 20;
         repeat (ITEMS_PER_PHASE) send_item(random_item(kind));
         drain();
      end

      if (mismatches == 0 && in_flight == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/dcpc_pkg.sv
src/dcpc_decode.sv
src/dcpc_horner_step.sv
src/dcpc_output.sv
src/dual_cubic_pitch_compensator_core.sv
tb/pitch_comp_checker.sv
tb/tb_dual_cubic_pitch_compensator_core.sv
